// File: rtl/scd_pkg.sv
// Shared constants, types and the LFO sine table for the stereo chorus core.
package scd_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int DELAY_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int FRAC_W      = 8;
	localparam int POS_W       = ADDR_W + FRAC_W;
	localparam int LFO_BITS    = 10;
	localparam int LFO_N       = 1 << LFO_BITS;
	localparam int LFO_W       = 16;
	localparam int PHASE_W     = 32;
	localparam int MIX_W       = 17;
	localparam int DELAY_W     = 20;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int MIX_ONE     = 65536;
	localparam int MIX_BYPASS  = 66;
	localparam int DELAY_LIMIT = (DELAY_DEPTH - 2) * 256;
	localparam int WET_W       = SAMPLE_W + 10;
	localparam int ACC_W       = WET_W + MIX_W + 1;
	localparam int OFS_W       = DELAY_W + LFO_W;
	localparam logic [PHASE_W-1:0] RPHASE_RESET = 32'h4000_0000;
	localparam int QUARTER_N   = LFO_N / 4;

	// Taylor series divisors (2n)(2n+1) for n = 1..7
	localparam longint unsigned TAYLOR_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIX   = 2'd0,
		REG_INC   = 2'd1,
		REG_BASE  = 2'd2,
		REG_DEPTH = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LFO, ST_DELAY, ST_ADDR,
		ST_RD0, ST_RD1, ST_WET, ST_MIX, ST_SUM
	} seq_state_t;

	typedef struct packed {
		logic clr;
		logic lfo;
		logic dly;
		logic addr;
		logic rd0;
		logic rd1;
		logic wet;
		logic mix;
	} lane_ctrl_t;

	typedef logic [LFO_W-1:0] lfo_table_t [LFO_N];

	// Quarter-wave Taylor sine in Q30, evaluated at elaboration only.
	function automatic longint quarter_sine_q30(input longint unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (r * 64'd6746518852) >> LFO_BITS;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
		return sum;
	endfunction

	function automatic lfo_table_t build_lfo_table();
		lfo_table_t t;
		int q;
		int r;
		int ang;
		longint s;
		longint v;
		for (int k = 0; k < LFO_N; k++) begin
			q = k >> (LFO_BITS - 2);
			r = k & (QUARTER_N - 1);
			ang = ((q & 1) == 1) ? QUARTER_N - r : r;
			s = quarter_sine_q30(longint'(ang));
			v = (q >= 2) ? (64'sd1 <<< 30) - s : (64'sd1 <<< 30) + s;
			v = (v + (64'sd1 <<< 15)) >>> 16;
			if (v > 32768) v = 32768;
			t[k] = LFO_W'(v);
		end
		return t;
	endfunction

	localparam lfo_table_t LFO_TABLE = build_lfo_table();

endpackage

// File: rtl/scd_lane.sv
// One chorus channel: LFO lookup, delay store, interpolation and dry/wet mix.
module scd_lane (
	input  logic                          clk,
	input  scd_pkg::lane_ctrl_t           ctrl,
	input  logic [scd_pkg::ADDR_W-1:0]    clr_addr,
	input  logic [scd_pkg::ADDR_W-1:0]    wp,
	input  logic [scd_pkg::PHASE_W-1:0]   phase,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] dry,
	input  logic [scd_pkg::MIX_W-1:0]     mix,
	input  logic [scd_pkg::DELAY_W-1:0]   base,
	input  logic [scd_pkg::DELAY_W-1:0]   depth,
	output logic signed [scd_pkg::SAMPLE_W-1:0] result
);
	import scd_pkg::*;

	logic [SAMPLE_W-1:0]        mem [DELAY_DEPTH];
	logic [SAMPLE_W-1:0]        rdata_q;
	logic [LFO_W-1:0]           lfo_q;
	logic [DELAY_W-1:0]         delay_q;
	logic [ADDR_W-1:0]          i0_q;
	logic [FRAC_W-1:0]          f_q;
	logic signed [WET_W-1:0]    p0_q;
	logic signed [WET_W-1:0]    wet_q;
	logic signed [ACC_W-1:0]    a_q;
	logic signed [ACC_W-1:0]    b_q;

	logic                       we;
	logic [ADDR_W-1:0]          waddr;
	logic [SAMPLE_W-1:0]        wdata;
	logic [ADDR_W-1:0]          raddr;
	logic [OFS_W-1:0]           ofs_prod;
	logic [DELAY_W+1:0]         delay_sum;
	logic [POS_W:0]             rp;
	logic signed [FRAC_W+1:0]   w0;
	logic signed [FRAC_W+1:0]   w1;
	logic signed [MIX_W:0]      dry_w;
	logic signed [MIX_W:0]      wet_w;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-25:0]   rounded;

	always_comb begin
		we = ctrl.clr | ctrl.lfo;
		waddr = ctrl.clr ? clr_addr : wp;
		wdata = ctrl.clr ? '0 : dry;
		raddr = ctrl.rd1 ? ADDR_W'(i0_q + 1'b1) : i0_q;
		ofs_prod = OFS_W'(depth) * OFS_W'(lfo_q);
		delay_sum = (DELAY_W+2)'(base) + (DELAY_W+2)'(ofs_prod >> 15);
		// store length is a power of two, so the wrap is the dropped top bit
		rp = {1'b0, wp, {FRAC_W{1'b0}}} + (POS_W+1)'(DELAY_DEPTH * 256)
			- (POS_W+1)'(delay_q);
		w0 = $signed({1'b0, (FRAC_W+1)'((FRAC_W+1)'(256) - (FRAC_W+1)'(f_q))});
		w1 = $signed({2'b0, f_q});
		dry_w = $signed({1'b0, MIX_W'(MIX_W'(MIX_ONE) - mix)});
		wet_w = $signed({1'b0, mix});
		acc = (a_q <<< 8) + b_q + ACC_W'(1 << 23);
		rounded = acc[ACC_W-1:24];
		if (rounded > $signed((ACC_W-24)'((1 << (SAMPLE_W - 1)) - 1)))
			result = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else if (rounded < -$signed((ACC_W-24)'(1 << (SAMPLE_W - 1))))
			result = {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			result = rounded[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.lfo) lfo_q <= LFO_TABLE[phase[PHASE_W-1 -: LFO_BITS]];
		if (ctrl.dly) begin
			if (delay_sum > (DELAY_W+2)'(DELAY_LIMIT)) delay_q <= DELAY_W'(DELAY_LIMIT);
			else delay_q <= delay_sum[DELAY_W-1:0];
		end
		if (ctrl.addr) begin
			i0_q <= rp[POS_W-1:FRAC_W];
			f_q <= rp[FRAC_W-1:0];
		end
		if (ctrl.rd1) p0_q <= WET_W'($signed(rdata_q) * w0);
		if (ctrl.wet) wet_q <= p0_q + WET_W'($signed(rdata_q) * w1);
		if (ctrl.mix) begin
			a_q <= ACC_W'(dry * dry_w);
			b_q <= ACC_W'(wet_q * wet_w);
		end
	end

endmodule

// File: rtl/stereo_chorus_delay_core.sv
// Stereo chorus top level: registers, sequencer, two channel lanes and output word.
// A word is taken only in idle and steps through the LFO, delay, address, two read,
// wet, mix and sum states (bypass goes straight to sum); sum waits for a free output.
// Each delay store has one read port: write, two reads, then multiply steps.
// After reset both stores are cleared, one entry a cycle through all 4096 entries,
// before the first input word is taken; configuration writes are taken throughout.
module stereo_chorus_delay_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [47:0]                 s_axis_tdata,  // left_in[23:0], right_in[47:24]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [47:0]                 m_axis_tdata,  // left_out[23:0], right_out[47:24]
	input  logic                        cfg_we,
	input  logic [scd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scd_pkg::CFG_W-1:0]   cfg_data
);
	import scd_pkg::*;

	logic [MIX_W-1:0]            mix_q;
	logic [PHASE_W-1:0]          inc_q;
	logic [DELAY_W-1:0]          base_q;
	logic [DELAY_W-1:0]          depth_q;
	logic [PHASE_W-1:0]          lphase_q;
	logic [PHASE_W-1:0]          rphase_q;
	logic [ADDR_W-1:0]           wp_q;
	logic [ADDR_W-1:0]           clr_cnt_q;
	logic signed [SAMPLE_W-1:0]  dry_l_q;
	logic signed [SAMPLE_W-1:0]  dry_r_q;
	logic                        byp_q;
	logic                        out_valid_q;
	logic [2*SAMPLE_W-1:0]       out_data_q;
	seq_state_t                  state_q;
	seq_state_t                  state_nx;

	logic [MIX_W-1:0]            mix_eff;
	logic                        bypass;
	logic                        in_acc;
	logic                        out_free;
	logic                        load_out;
	lane_ctrl_t                  ctrl;
	logic signed [SAMPLE_W-1:0]  res_l;
	logic signed [SAMPLE_W-1:0]  res_r;

	always_comb begin
		mix_eff = (mix_q > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : mix_q;
		bypass = mix_eff < MIX_W'(MIX_BYPASS);
		out_free = !out_valid_q || m_axis_tready;
		in_acc = s_axis_tvalid && s_axis_tready;
		load_out = (state_q == ST_SUM) && out_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: if (clr_cnt_q == ADDR_W'(DELAY_DEPTH - 1)) state_nx = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_nx = bypass ? ST_SUM : ST_LFO;
			ST_LFO:   state_nx = ST_DELAY;
			ST_DELAY: state_nx = ST_ADDR;
			ST_ADDR:  state_nx = ST_RD0;
			ST_RD0:   state_nx = ST_RD1;
			ST_RD1:   state_nx = ST_WET;
			ST_WET:   state_nx = ST_MIX;
			ST_MIX:   state_nx = ST_SUM;
			ST_SUM:   if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_CLEAR: ctrl.clr = 1'b1;
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_LFO:   ctrl.lfo = 1'b1;
			ST_DELAY: ctrl.dly = 1'b1;
			ST_ADDR:  ctrl.addr = 1'b1;
			ST_RD0:   ctrl.rd0 = 1'b1;
			ST_RD1:   ctrl.rd1 = 1'b1;
			ST_WET:   ctrl.wet = 1'b1;
			ST_MIX:   ctrl.mix = 1'b1;
			default:  ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= MIX_W'(32768);
			inc_q <= PHASE_W'(44739);
			base_q <= DELAY_W'(86016);
			depth_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIX:   mix_q <= cfg_data[MIX_W-1:0];
				REG_INC:   inc_q <= cfg_data[PHASE_W-1:0];
				REG_BASE:  base_q <= cfg_data[DELAY_W-1:0];
				REG_DEPTH: depth_q <= cfg_data[DELAY_W-1:0];
				default:   mix_q <= mix_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			lphase_q <= '0;
			rphase_q <= RPHASE_RESET;
			wp_q <= '0;
			byp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) clr_cnt_q <= ADDR_W'(clr_cnt_q + 1'b1);
			if (in_acc) byp_q <= bypass;
			// advance both LFOs once per non-bypassed word
			if (ctrl.lfo) begin
				lphase_q <= lphase_q + inc_q;
				rphase_q <= rphase_q + inc_q;
			end
			if (load_out && !byp_q) wp_q <= ADDR_W'(wp_q + 1'b1);
			if (load_out) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dry_l_q <= s_axis_tdata[SAMPLE_W-1:0];
			dry_r_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
		if (load_out) out_data_q <= byp_q ? {dry_r_q, dry_l_q} : {res_r, res_l};
	end

	scd_lane u_lane_l (
		.clk      (clk),
		.ctrl     (ctrl),
		.clr_addr (clr_cnt_q),
		.wp       (wp_q),
		.phase    (lphase_q),
		.dry      (dry_l_q),
		.mix      (mix_eff),
		.base     (base_q),
		.depth    (depth_q),
		.result   (res_l)
	);

	scd_lane u_lane_r (
		.clk      (clk),
		.ctrl     (ctrl),
		.clr_addr (clr_cnt_q),
		.wp       (wp_q),
		.phase    (rphase_q),
		.dry      (dry_r_q),
		.mix      (mix_eff),
		.base     (base_q),
		.depth    (depth_q),
		.result   (res_r)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("input taken during store clear");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !byp_q) |=> (wp_q == ADDR_W'($past(wp_q) + 1'b1)))
		else $error("write pointer did not advance");

	a_bypass_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && bypass) |=> ##1 ($stable(lphase_q) && $stable(wp_q)))
		else $error("state moved on a bypassed word");

	a_phase_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rphase_q - lphase_q) == RPHASE_RESET)
		else $error("LFO phases drifted apart");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the stereo chorus core: directed table, then random phases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import scd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 14;
	localparam int HOLD_CYCLES    = 400;
	localparam int RAND_PHASES    = 10;
	localparam int PHASE_WORDS    = 75;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_DATA, ROW_CHECKED} row_kind_t;
	typedef struct {
		row_kind_t kind;
		cfg_reg_t  idx;
		logic [CFG_W-1:0] val;
		pair_t     din;
		pair_t     dexp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	always #10 clk = ~clk;

	stereo_chorus_delay_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// chorus state mirror
	logic [15:0] sine_lut [LFO_N];
	longint      delay_line [2][DELAY_DEPTH];
	int unsigned wr_ptr;
	logic [31:0] lfo_phase [2];
	logic [31:0] wet_mix, phase_step, delay_base, delay_depth;

	pair_t expected_pairs [$];
	stim_row_t rows [$];
	int  errors = 0;
	bit  idle_en = 1'b1;
	bit  hold_req = 1'b0;

	function automatic longint taylor_sine(input int unsigned a);
		longint unsigned x, x2, term;
		longint acc;
		x = (longint'(a) * 64'd6746518852) >> LFO_BITS;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
		return acc;
	endfunction

	task automatic build_sine_lut();
		int unsigned qd, rm, ang;
		longint v;
		for (int k = 0; k < LFO_N; k++) begin
			qd = k / (LFO_N / 4);
			rm = k % (LFO_N / 4);
			ang = (qd % 2 == 1) ? (LFO_N / 4) - rm : rm;
			v = (qd >= 2) ? (64'sd1 <<< 30) - taylor_sine(ang)
				: (64'sd1 <<< 30) + taylor_sine(ang);
			v = (v + (64'sd1 <<< 15)) >>> 16;
			if (v > 32768) v = 32768;
			sine_lut[k] = v[15:0];
		end
	endtask

	task automatic mirror_reset();
		foreach (delay_line[c, i]) delay_line[c][i] = 0;
		wr_ptr = 0;
		lfo_phase[0] = '0;
		lfo_phase[1] = 32'h4000_0000;
		wet_mix = 32768;
		phase_step = 44739;
		delay_base = 86016;
		delay_depth = 0;
	endtask

	task automatic mirror_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_MIX:   wet_mix = val & 32'h1FFFF;
			REG_INC:   phase_step = val;
			REG_BASE:  delay_base = val & 32'hFFFFF;
			REG_DEPTH: delay_depth = val & 32'hFFFFF;
			default: ;
		endcase
	endtask

	// compute the mixed pair for one input word and, unless bypassed, advance the mirror
	task automatic chorus_predict(input pair_t din, output pair_t dout);
		longint m, dly, rp, i0, i1, fr, wet, acc, v, dry;
		logic [15:0] lfo [2];
		sample_t res [2];
		m = (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;
		if (m < MIX_BYPASS) begin
			dout = din;
			return;
		end
		lfo[0] = sine_lut[lfo_phase[0][31:22]];
		lfo[1] = sine_lut[lfo_phase[1][31:22]];
		lfo_phase[0] += phase_step;
		lfo_phase[1] += phase_step;
		for (int c = 0; c < 2; c++) begin
			dry = (c == 0) ? longint'(din.left) : longint'(din.right);
			dly = longint'(delay_base) + ((longint'(delay_depth) * longint'(lfo[c])) >>> 15);
			if (dly > DELAY_LIMIT) dly = DELAY_LIMIT;
			delay_line[c][wr_ptr] = dry;
			rp = longint'(wr_ptr) * 256 + DELAY_DEPTH * 256 - dly;
			if (rp >= DELAY_DEPTH * 256) rp -= DELAY_DEPTH * 256;
			i0 = (rp >>> 8) % DELAY_DEPTH;
			i1 = (i0 + 1) % DELAY_DEPTH;
			fr = rp & 255;
			wet = delay_line[c][i0] * (256 - fr) + delay_line[c][i1] * fr;
			acc = dry * (MIX_ONE - m) * 256 + wet * m;
			v = (acc + (64'sd1 <<< 23)) >>> 24;
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			res[c] = v[SAMPLE_W-1:0];
		end
		dout.left = res[0];
		dout.right = res[1];
		wr_ptr = (wr_ptr + 1 >= DELAY_DEPTH) ? 0 : wr_ptr + 1;
	endtask

	task automatic report_mismatch(input string what, input sample_t got, input sample_t exp_v);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, exp_v);
		errors++;
	endtask

	task automatic wait_drain();
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_write(idx, val);
	endtask

	// offer one word, hold until taken; valid stays high when no gap follows
	task automatic send_word(input pair_t din, input bit has_exp, input pair_t dexp);
		pair_t pred;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {din.right, din.left};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chorus_predict(din, pred);
		expected_pairs.push_back(has_exp ? dexp : pred);
	endtask

	task automatic idle_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic pair_t mk_pair(input int l, input int r);
		pair_t p;
		p.left = l[SAMPLE_W-1:0];
		p.right = r[SAMPLE_W-1:0];
		return p;
	endfunction

	task automatic add_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.val = val;
		rows.push_back(row);
	endtask

	task automatic add_data(input row_kind_t kind, input pair_t din, input pair_t dexp);
		stim_row_t row;
		row.kind = kind;
		row.din = din;
		row.dexp = dexp;
		rows.push_back(row);
	endtask

	// receiver: check every taken word, then choose tready for the next cycle
	initial begin : receiver
		int stall;
		int hold;
		bit rdy;
		pair_t got, want;
		stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[23:0], m_axis_tdata[47:24]};
				if (expected_pairs.size() == 0) begin
					$display("%0t: output word with nothing expected", $realtime);
					errors++;
				end else begin
					want = expected_pairs.pop_front();
					if (got.left !== want.left) report_mismatch("left_out", got.left, want.left);
					if (got.right !== want.right)
						report_mismatch("right_out", got.right, want.right);
				end
			end
			if (hold_req && hold == 0) begin
				hold = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else if (stall > 0) begin
				stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (idle_en && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 6);
			end
			m_axis_tready <= rdy;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("** stereo_chorus_delay_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		pair_t none;
		pair_t p;
		none = '0;
		build_sine_lut();
		mirror_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, empty store: half of the dry word, rounded half up
		add_data(ROW_CHECKED, mk_pair(8388607, -8388608), mk_pair(4194304, -4194304));
		add_data(ROW_CHECKED, mk_pair(-8388608, 8388607), mk_pair(-4194304, 4194304));
		add_data(ROW_CHECKED, mk_pair(0, -1), mk_pair(0, 0));
		add_data(ROW_CHECKED, mk_pair(1, -2), mk_pair(1, -1));
		// bypass below the threshold
		add_cfg(REG_MIX, 0);
		add_data(ROW_CHECKED, mk_pair(123456, -654321), mk_pair(123456, -654321));
		add_data(ROW_CHECKED, mk_pair(8388607, -8388608), mk_pair(8388607, -8388608));
		add_cfg(REG_MIX, 65);
		add_data(ROW_CHECKED, mk_pair(-77, 99), mk_pair(-77, 99));
		add_cfg(REG_MIX, 66);
		add_data(ROW_DATA, mk_pair(1000, -1000), none);
		// all wet with zero delay reads back the word just written
		add_cfg(REG_BASE, 0);
		add_cfg(REG_MIX, 65536);
		add_data(ROW_CHECKED, mk_pair(8388607, -8388608), mk_pair(8388607, -8388608));
		add_cfg(REG_MIX, 32'h1FFFF);
		add_data(ROW_CHECKED, mk_pair(-5, 7), mk_pair(-5, 7));
		// half-sample delay, then saturated long delay with phase wrap
		add_cfg(REG_BASE, 32'h80);
		add_data(ROW_DATA, mk_pair(4000, -4000), none);
		add_data(ROW_DATA, mk_pair(-8388608, 8388607), none);
		add_cfg(REG_BASE, 32'hFFFFF);
		add_cfg(REG_DEPTH, 32'hFFFFF);
		add_cfg(REG_INC, 32'hFFFF_FFFF);
		add_cfg(REG_MIX, 40000);
		add_data(ROW_DATA, mk_pair(8388607, 8388607), none);
		add_data(ROW_DATA, mk_pair(-8388608, -8388608), none);
		add_cfg(REG_INC, 32'h0800_0000);
		add_cfg(REG_BASE, 32'h100);
		add_cfg(REG_DEPTH, 32'h4000);
		add_data(ROW_DATA, mk_pair(300000, -300000), none);
		add_data(ROW_DATA, mk_pair(-1, 1), none);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				idle_input();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_word(rows[i].din, rows[i].kind == ROW_CHECKED, rows[i].dexp);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_input();
			if (ph == RAND_PHASES - 2) idle_en = 1'b0;
			case (ph % 4)
				0: write_reg(REG_MIX, $urandom_range(66, 65536));
				1: write_reg(REG_MIX, $urandom);
				2: write_reg(REG_MIX, ($urandom_range(0, 7) == 0) ? 32'd10 : 32'd65536);
				default: write_reg(REG_MIX, $urandom_range(20000, 50000));
			endcase
			write_reg(REG_INC, (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h0400_0000));
			write_reg(REG_BASE, (ph % 4 == 3) ? $urandom : $urandom_range(0, 200 * 256));
			write_reg(REG_DEPTH, (ph % 5 == 4) ? $urandom : $urandom_range(0, 100 * 256));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (ph == 3 && k == 10) hold_req = 1'b1;
				if (ph == 5 && k == 40) begin
					idle_input();
					wait_drain();
				end
				p.left = rand_sample();
				p.right = rand_sample();
				send_word(p, 1'b0, none);
			end
		end
		idle_input();

		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) $display("** stereo_chorus_delay_core: PASSED **");
		else $display("** stereo_chorus_delay_core: FAILED **");
		$finish;
	end

endmodule

// File: files.f
rtl/scd_pkg.sv
rtl/scd_lane.sv
rtl/stereo_chorus_delay_core.sv
tb/tb_top.sv
